>>> rtl/pv_pkg.sv
// Shared types and constants for the POLYVAL hash block.
package pv_pkg;

	localparam int unsigned HALF_W   = 64;
	localparam int unsigned BLOCK_W  = 2 * HALF_W;
	localparam int unsigned DIGIT_W  = 16;
	localparam int unsigned STEPS    = BLOCK_W / DIGIT_W;
	localparam int unsigned STEP_W   = $clog2(STEPS);
	localparam int unsigned BYTES    = BLOCK_W / 8;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned PROD_W   = BLOCK_W + DIGIT_W - 1;
	localparam int unsigned IN_W     = 136;
	localparam int unsigned CFG_IDX_W = 2;

	// x^-1 folds a set low coefficient into x^127 + x^126 + x^125 + x^120.
	localparam logic [BLOCK_W-1:0] REDUCE = {8'hE1, 120'd0};

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_HIGH = 2'd3;

	typedef enum logic [1:0] {
		PV_IDLE,
		PV_MUL,
		PV_FIN
	} pv_state_t;

endpackage

>>> rtl/pv_gfmul.sv
// Digit-serial GF(2^128) multiplier computing a * b * x^-128, 16 bits of a per cycle.
module pv_gfmul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pv_pkg::BLOCK_W-1:0]    a,
	input  logic [pv_pkg::BLOCK_W-1:0]    b,
	output logic                          busy,
	output logic                          done,
	output logic [pv_pkg::BLOCK_W-1:0]    result
);

	logic [pv_pkg::BLOCK_W-1:0] a_q;
	logic [pv_pkg::BLOCK_W-1:0] r_q;
	logic [pv_pkg::STEP_W-1:0]  cnt_q;
	logic                       busy_q;
	logic [pv_pkg::PROD_W-1:0]  prod;
	logic [pv_pkg::BLOCK_W-1:0] next_r;

	// One digit: add digit * b to the partial result, then multiply by x^-16.
	// The fold masks never reach the low sixteen bits, so every low bit folds
	// independently of the others.
	always_comb begin
		prod = {{(pv_pkg::DIGIT_W-1){1'b0}}, r_q};
		for (int j = 0; j < int'(pv_pkg::DIGIT_W); j++) begin
			if (a_q[j]) begin
				prod = prod ^ ({{(pv_pkg::DIGIT_W-1){1'b0}}, b} << j);
			end
		end
		next_r = {1'b0, prod[pv_pkg::PROD_W-1:pv_pkg::DIGIT_W]};
		for (int s = 0; s < int'(pv_pkg::DIGIT_W); s++) begin
			if (prod[s]) begin
				next_r = next_r ^ (pv_pkg::REDUCE >> (int'(pv_pkg::DIGIT_W) - 1 - s));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == pv_pkg::STEP_W'(pv_pkg::STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= a_q >> pv_pkg::DIGIT_W;
			r_q <= next_r;
		end
	end

	assign busy   = busy_q;
	assign done   = busy_q && (cnt_q == pv_pkg::STEP_W'(pv_pkg::STEPS - 1));
	assign result = next_r;

endmodule

>>> rtl/polyval_hash.sv
// POLYVAL hash top level: configuration, message control and result register.
// In the cycle a block is accepted, its bytes are masked, the masked block is
// xored onto the accumulator value and the sum is loaded into the
// digit-serial multiplier, which then consumes sixteen bits of the operand per
// cycle against the full key. A block with no valid bytes skips the
// multiplier. A last block then moves the tag into the output register in a
// finishing state, and waits there while an earlier tag has not been taken.
// The key and init registers must only be written while no block is in work.
module polyval_hash (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [pv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pv_pkg::HALF_W-1:0]       cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// block_low [63:0], block_high [127:64], valid_bytes [132:128], zero pad
	input  logic [pv_pkg::IN_W-1:0]         s_tdata,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tag_low [63:0], tag_high [127:64]
	output logic [pv_pkg::BLOCK_W-1:0]      m_tdata
);

	logic [pv_pkg::BLOCK_W-1:0] key_q;
	logic [pv_pkg::BLOCK_W-1:0] init_q;
	logic [pv_pkg::BLOCK_W-1:0] acc_q;
	logic [pv_pkg::BLOCK_W-1:0] out_q;
	logic                       out_valid_q;
	logic                       open_q;
	logic                       last_q;
	pv_pkg::pv_state_t          state_q;
	pv_pkg::pv_state_t          state_d;

	logic                       accept;
	logic                       emit;
	logic [pv_pkg::COUNT_W-1:0] vb_raw;
	logic [pv_pkg::COUNT_W-1:0] vb_sat;
	logic [pv_pkg::BLOCK_W-1:0] byte_mask;
	logic [pv_pkg::BLOCK_W-1:0] base;
	logic [pv_pkg::BLOCK_W-1:0] operand;
	logic                       mul_start;
	logic                       mul_busy;
	logic                       mul_done;
	logic [pv_pkg::BLOCK_W-1:0] mul_result;

	assign vb_raw = s_tdata[pv_pkg::BLOCK_W +: pv_pkg::COUNT_W];
	assign vb_sat = (vb_raw > pv_pkg::COUNT_W'(pv_pkg::BYTES)) ?
			pv_pkg::COUNT_W'(pv_pkg::BYTES) : vb_raw;

	always_comb begin
		for (int i = 0; i < int'(pv_pkg::BYTES); i++) begin
			byte_mask[8*i +: 8] = (pv_pkg::COUNT_W'(i) < vb_sat) ? 8'hFF : 8'h00;
		end
	end

	// A new message starts from the init value rather than the old accumulator.
	assign base      = open_q ? acc_q : init_q;
	assign operand   = base ^ (s_tdata[pv_pkg::BLOCK_W-1:0] & byte_mask);
	assign accept    = s_tvalid && s_tready;
	assign mul_start = accept && (vb_sat != '0);

	pv_gfmul u_gfmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (operand),
		.b      (key_q),
		.busy   (mul_busy),
		.done   (mul_done),
		.result (mul_result)
	);

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		emit     = 1'b0;
		case (state_q)
			pv_pkg::PV_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (vb_sat != '0) begin
						state_d = pv_pkg::PV_MUL;
					end else if (s_tlast) begin
						state_d = pv_pkg::PV_FIN;
					end
				end
			end
			pv_pkg::PV_MUL: begin
				if (mul_done) begin
					state_d = last_q ? pv_pkg::PV_FIN : pv_pkg::PV_IDLE;
				end
			end
			pv_pkg::PV_FIN: begin
				if (!out_valid_q || m_tready) begin
					emit    = 1'b1;
					state_d = pv_pkg::PV_IDLE;
				end
			end
			default: begin
				state_d = pv_pkg::PV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pv_pkg::PV_IDLE;
			out_valid_q <= 1'b0;
			open_q      <= 1'b0;
			key_q       <= '0;
			init_q      <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				open_q <= !s_tlast;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					pv_pkg::REG_KEY_LOW:   key_q[pv_pkg::HALF_W-1:0] <= cfg_data;
					pv_pkg::REG_KEY_HIGH:  key_q[pv_pkg::BLOCK_W-1:pv_pkg::HALF_W] <= cfg_data;
					pv_pkg::REG_INIT_LOW:  init_q[pv_pkg::HALF_W-1:0] <= cfg_data;
					pv_pkg::REG_INIT_HIGH: init_q[pv_pkg::BLOCK_W-1:pv_pkg::HALF_W] <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q  <= base;
			last_q <= s_tlast;
		end else if (mul_done) begin
			acc_q <= mul_result;
		end
		if (emit) begin
			out_q <= acc_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// The multiplier only runs while the controller waits on it.
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_busy |-> (state_q == pv_pkg::PV_MUL))
		else $error("multiplier busy outside the multiply state");

	// A block with valid bytes always starts the multiplier.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (vb_sat != '0)) |=> mul_busy)
		else $error("accepted block did not start the multiplier");

	// No new block is taken while a multiplication is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_busy |-> !s_tready)
		else $error("input ready while multiplier busy");

	// Moving a tag out always leaves a valid result behind.
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_tvalid)
		else $error("emitted tag not presented");

endmodule
